@@ hw/rtl/half_float_rgb_to_gamma_bgr8_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the half-float to gamma BGR8 block
// Shared helpers for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef HALF_FLOAT_RGB_TO_GAMMA_BGR8_DEFINES_SVH
`define HALF_FLOAT_RGB_TO_GAMMA_BGR8_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define HFG_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define HFG_ASSERT(lbl, prop, msg) \
  `HFG_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ hw/rtl/hfg_pkg.sv @@
// ----------------------------------------------------------------------------
// hfg_pkg
// Constants and the gamma threshold table for the half-float to BGR8 block.
// ----------------------------------------------------------------------------
package hfg_pkg;

  localparam int HalfW = 16;
  localparam int ByteW = 8;
  localparam int MagW  = 15;
  localparam int BigW  = 448;
  localparam int GammaNum = 22;
  localparam int GammaDen = 10;
  localparam int ByteMax  = 255;

  localparam logic [MagW-1:0] HalfInf = 15'h7C00;
  localparam logic [MagW-1:0] HalfOne = 15'h3C00;
  localparam logic [ByteW-1:0] ByteFull = 8'hFF;

  typedef logic [MagW-1:0] thr_tab_t [256];

  function automatic logic [BigW-1:0] big_pow(logic [BigW-1:0] base, int n);
    logic [BigW-1:0] acc;
    acc = BigW'(1);
    for (int i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Exact test (k/255)^2.2 <= x(h) for a positive finite half h.
  function automatic bit thr_ok(logic [BigW-1:0] k_pow, logic [BigW-1:0] full_pow,
                                logic [MagW-1:0] h);
    logic [4:0]      ex;
    logic [10:0]     mant;
    int              shift;
    logic [BigW-1:0] lhs;
    logic [BigW-1:0] rhs;
    ex = h[14:10];
    if (ex == 5'd0) begin
      mant  = {1'b0, h[9:0]};
      shift = 240;
    end else begin
      mant  = {1'b1, h[9:0]};
      shift = 10 * (25 - int'(ex));
    end
    lhs = k_pow << shift;
    rhs = full_pow * big_pow(BigW'(mant), GammaDen);
    return (lhs <= rhs);
  endfunction

  // Entry k is the smallest half pattern whose code is at least k.
  function automatic thr_tab_t build_thr();
    thr_tab_t        tab;
    logic [BigW-1:0] full_pow;
    logic [BigW-1:0] k_pow;
    int              lo;
    int              hi;
    int              mid;
    full_pow = big_pow(BigW'(ByteMax), GammaNum);
    tab[0] = '0;
    for (int k = 1; k < 256; k++) begin
      k_pow = big_pow(BigW'(k), GammaNum);
      lo = 1;
      hi = int'(HalfOne);
      for (int it = 0; it < 16; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (thr_ok(k_pow, full_pow, MagW'(mid))) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      tab[k] = MagW'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t ThrTab = build_thr();

endpackage

@@ hw/rtl/hfg_chan_enc.sv @@
// ----------------------------------------------------------------------------
// hfg_chan_enc
// Encodes one half-float channel into a gamma 2.2 byte.
// ----------------------------------------------------------------------------
module hfg_chan_enc (
  input  logic [hfg_pkg::HalfW-1:0] half_i,
  output logic [hfg_pkg::ByteW-1:0] byte_o
);

  logic [hfg_pkg::MagW-1:0] mag;

  assign mag = half_i[hfg_pkg::MagW-1:0];

  // The thresholds rise with the code, so an eight-step search over the
  // constant table finds the largest code whose threshold is reached.
  always_comb begin
    logic [hfg_pkg::ByteW-1:0] lo;
    logic [hfg_pkg::ByteW-1:0] cand;
    lo   = '0;
    cand = '0;
    for (int b = hfg_pkg::ByteW - 1; b >= 0; b--) begin
      cand = lo | (8'd1 << b);
      if (hfg_pkg::ThrTab[cand] <= mag) begin
        lo = cand;
      end
    end
    if (half_i[hfg_pkg::HalfW-1]) begin
      byte_o = '0;
    end else if (mag > hfg_pkg::HalfInf) begin
      byte_o = '0;
    end else if (mag >= hfg_pkg::HalfOne) begin
      byte_o = hfg_pkg::ByteFull;
    end else begin
      byte_o = lo;
    end
  end

endmodule

@@ hw/rtl/half_float_rgb_to_gamma_bgr8.sv @@
// ----------------------------------------------------------------------------
// half_float_rgb_to_gamma_bgr8
// Converts one half-float RGB pixel per clock into gamma-encoded BGR bytes.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel beat is taken at a rising edge with start high and busy low.
//   busy stays low, so a new pixel can be given on every clock.
//   Each channel is an IEEE binary16 pattern. Negatives and NaN encode to 0,
//   values of one and above (and +infinity) to 255, all others to
//   floor(255 * x^(1/2.2)).
//   The pixel is registered at the input edge, encoded by a constant
//   threshold search per channel, and registered again at the next edge.
//   The result beat is then on the outputs for one cycle, marked by done_o,
//   and the receiver takes it while done_o is high.
//   Throughput is one pixel per cycle; each pixel passes through the
//   input and result registers.
//   The receiver cannot stall; it must take every result beat.
//   Reset clears both valid flags, so no result appears after reset until a
//   new pixel is accepted.
// ----------------------------------------------------------------------------
module half_float_rgb_to_gamma_bgr8 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [hfg_pkg::HalfW-1:0] red_half_i,
  input  logic [hfg_pkg::HalfW-1:0] green_half_i,
  input  logic [hfg_pkg::HalfW-1:0] blue_half_i,
  output logic                      done_o,
  output logic [hfg_pkg::ByteW-1:0] blue_byte_o,
  output logic [hfg_pkg::ByteW-1:0] green_byte_o,
  output logic [hfg_pkg::ByteW-1:0] red_byte_o
);

  logic                      in_valid_q;
  logic                      in_valid_d;
  logic [hfg_pkg::HalfW-1:0] red_q;
  logic [hfg_pkg::HalfW-1:0] green_q;
  logic [hfg_pkg::HalfW-1:0] blue_q;
  logic                      done_q;
  logic [hfg_pkg::ByteW-1:0] red_enc;
  logic [hfg_pkg::ByteW-1:0] green_enc;
  logic [hfg_pkg::ByteW-1:0] blue_enc;
  logic [hfg_pkg::ByteW-1:0] red_byte_q;
  logic [hfg_pkg::ByteW-1:0] green_byte_q;
  logic [hfg_pkg::ByteW-1:0] blue_byte_q;

  assign busy       = 1'b0;
  assign in_valid_d = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_d) begin
      red_q   <= red_half_i;
      green_q <= green_half_i;
      blue_q  <= blue_half_i;
    end
    if (in_valid_q) begin
      red_byte_q   <= red_enc;
      green_byte_q <= green_enc;
      blue_byte_q  <= blue_enc;
    end
  end

  hfg_chan_enc u_enc_red (
    .half_i (red_q),
    .byte_o (red_enc)
  );

  hfg_chan_enc u_enc_green (
    .half_i (green_q),
    .byte_o (green_enc)
  );

  hfg_chan_enc u_enc_blue (
    .half_i (blue_q),
    .byte_o (blue_enc)
  );

  assign done_o       = done_q;
  assign red_byte_o   = red_byte_q;
  assign green_byte_o = green_byte_q;
  assign blue_byte_o  = blue_byte_q;

endmodule

@@ hw/rtl/hfg_checker.sv @@
// ----------------------------------------------------------------------------
// hfg_checker
// Port-level checks for the half-float to gamma BGR8 block.
// ----------------------------------------------------------------------------
`include "half_float_rgb_to_gamma_bgr8_defines.svh"

module hfg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic [hfg_pkg::HalfW-1:0] red_half_i,
  input logic [hfg_pkg::HalfW-1:0] green_half_i,
  input logic [hfg_pkg::HalfW-1:0] blue_half_i,
  input logic                      done_o,
  input logic [hfg_pkg::ByteW-1:0] blue_byte_o,
  input logic [hfg_pkg::ByteW-1:0] green_byte_o,
  input logic [hfg_pkg::ByteW-1:0] red_byte_o
);

  logic beat_in;
  logic red_neg_in;
  logic green_nan_in;
  logic blue_sat_in;

  assign beat_in      = start && !busy;
  assign red_neg_in   = beat_in && red_half_i[15];
  assign green_nan_in = beat_in && (green_half_i[14:0] > hfg_pkg::HalfInf);
  assign blue_sat_in  = beat_in && !blue_half_i[15] &&
                        (blue_half_i[14:0] >= hfg_pkg::HalfOne) &&
                        (blue_half_i[14:0] <= hfg_pkg::HalfInf);

  // Every accepted pixel comes back as a result beat on done_o.
  `HFG_ASSERT(a_result_follows, beat_in |-> ##2 done_o, "accepted pixel gave no result")

  `HFG_ASSERT(a_no_spurious, done_o |-> $past(beat_in, 2), "result without a pixel")

  // A set sign bit always encodes to zero.
  `HFG_ASSERT(a_red_negative, red_neg_in |-> ##2 (red_byte_o == 8'h00), "negative red not zero")

  // NaN of either sign encodes to zero.
  `HFG_ASSERT(a_green_nan, green_nan_in |-> ##2 (green_byte_o == 8'h00), "NaN green not zero")

  // One, above one and +infinity saturate.
  `HFG_ASSERT(a_blue_saturate, blue_sat_in |-> ##2 (blue_byte_o == hfg_pkg::ByteFull), "blue not saturated")

endmodule

bind half_float_rgb_to_gamma_bgr8 hfg_checker u_hfg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .red_half_i   (red_half_i),
  .green_half_i (green_half_i),
  .blue_half_i  (blue_half_i),
  .done_o       (done_o),
  .blue_byte_o  (blue_byte_o),
  .green_byte_o (green_byte_o),
  .red_byte_o   (red_byte_o)
);
